### rtl/core/aalr_pkg.sv
// shared constants, types and codes of the antialiased line rasteriser
`timescale 1ns / 1ps

package aalr_pkg;

   // coordinate and fixed-point sizes
   localparam int COORD_BITS  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
   localparam int GRAD_BITS   = FRAC_BITS + 2;
   localparam int MAG_BITS    = FRAC_BITS + 1;
   localparam int WEIGHT_BITS = 8;

   // one quotient bit per step over the whole dividend
   localparam int DIV_STEPS = ACC_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

   localparam logic [WEIGHT_BITS:0]   WEIGHT_FULL = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
   localparam logic [WEIGHT_BITS:0]   WEIGHT_HALF = (WEIGHT_BITS + 1)'(1) << (WEIGHT_BITS - 1);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_NONE = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_GRADIENT,
      ST_FIRST,
      ST_SECOND,
      ST_INTERIOR
   } state_type;

   typedef enum logic [1:0] {
      EMIT_FIRST,
      EMIT_SECOND,
      EMIT_INTERIOR
   } emit_kind_type;

   typedef struct packed {
      logic          load;
      logic          div_step;
      logic          grad_load;
      logic          emit;
      emit_kind_type emit_kind;
   } cmd_type;

   typedef struct packed {
      logic dmaj_zero;
      logic dmaj_small;
      logic div_done;
      logic out_free;
      logic interior_last;
   } status_type;

endpackage

### rtl/core/aalr_controller.sv
// sequencing state machine of the antialiased line rasteriser
`timescale 1ns / 1ps

module aalr_controller
   import aalr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.grad_load = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_kind = EMIT_FIRST;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            // no word is taken while reset is held
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.dmaj_zero || status.div_done) begin
               state_in = ST_GRADIENT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_GRADIENT: begin
            cmd.grad_load = 1'b1;
            state_in      = ST_FIRST;
         end
         ST_FIRST: begin
            cmd.emit_kind = EMIT_FIRST;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SECOND;
            end
         end
         ST_SECOND: begin
            cmd.emit_kind = EMIT_SECOND;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.dmaj_small ? ST_IDLE : ST_INTERIOR;
            end
         end
         ST_INTERIOR: begin
            cmd.emit_kind = EMIT_INTERIOR;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.interior_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/aalr_datapath.sv
// endpoint ordering, gradient divider, minor accumulator and result register
`timescale 1ns / 1ps

module aalr_datapath
   import aalr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y,
   output logic                   rsp_far_on_x,
   output logic [WEIGHT_BITS:0]   rsp_weight_near,
   output logic [WEIGHT_BITS-1:0] rsp_weight_far,
   output logic                   rsp_last
);

   // line geometry, held for the whole line
   logic [COORD_BITS-1:0] ma_ff, na_ff, mb_ff, nb_ff, dmaj_ff;
   logic                  steep_ff, neg_ff;

   // divider
   logic [COORD_BITS-1:0] rem_ff;
   logic [ACC_BITS-1:0]   dvd_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic [GRAD_BITS-1:0]  grad_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [COORD_BITS-1:0] col_ff;

   // result register
   logic                   out_valid_ff;
   logic [COORD_BITS-1:0]  out_x_ff, out_y_ff;
   logic                   out_far_x_ff;
   logic [WEIGHT_BITS:0]   out_near_ff;
   logic [WEIGHT_BITS-1:0] out_far_ff;
   logic                   out_last_ff;

   // input decode
   logic [COORD_BITS-1:0] adx, ady, maj_a, min_a, maj_b, min_b;
   logic [COORD_BITS-1:0] ma_in, na_in, mb_in, nb_in, dmin_abs;
   logic                  steep_in, swap;

   always_comb begin
      adx      = (req_end_x > req_start_x) ? (req_end_x - req_start_x)
                                           : (req_start_x - req_end_x);
      ady      = (req_end_y > req_start_y) ? (req_end_y - req_start_y)
                                           : (req_start_y - req_end_y);
      steep_in = ady > adx;
      maj_a    = steep_in ? req_start_y : req_start_x;
      min_a    = steep_in ? req_start_x : req_start_y;
      maj_b    = steep_in ? req_end_y : req_end_x;
      min_b    = steep_in ? req_end_x : req_end_y;
      swap     = maj_a > maj_b;
      ma_in    = swap ? maj_b : maj_a;
      na_in    = swap ? min_b : min_a;
      mb_in    = swap ? maj_a : maj_b;
      nb_in    = swap ? min_a : min_b;
      dmin_abs = (nb_in < na_in) ? (na_in - nb_in) : (nb_in - na_in);
   end

   // restoring divide step
   logic [COORD_BITS:0]   rem_sh;
   logic                  q_bit;
   logic [COORD_BITS:0]   rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[ACC_BITS-1]};
      q_bit   = rem_sh >= {1'b0, dmaj_ff};
      rem_sub = rem_sh - {1'b0, dmaj_ff};
   end

   // gradient from quotient
   logic [MAG_BITS-1:0]  mag;
   logic [GRAD_BITS-1:0] grad_mag, grad_in;

   always_comb begin
      mag      = (dmaj_ff == '0) ? (MAG_BITS'(1) << FRAC_BITS) : dvd_ff[MAG_BITS-1:0];
      grad_mag = {1'b0, mag};
      grad_in  = neg_ff ? (GRAD_BITS'(0) - grad_mag) : grad_mag;
   end

   logic [ACC_BITS-1:0] grad_ext;
   logic [COORD_BITS:0] col_next;

   assign grad_ext = {{(ACC_BITS - GRAD_BITS){grad_ff[GRAD_BITS-1]}}, grad_ff};
   assign col_next = {1'b0, col_ff} + (COORD_BITS + 1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ma_ff    <= ma_in;
         na_ff    <= na_in;
         mb_ff    <= mb_in;
         nb_ff    <= nb_in;
         dmaj_ff  <= mb_in - ma_in;
         steep_ff <= steep_in;
         neg_ff   <= nb_in < na_in;
         rem_ff   <= '0;
         dvd_ff   <= {dmin_abs, {FRAC_BITS{1'b0}}};
         cnt_ff   <= CNT_BITS'(DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
         dvd_ff <= {dvd_ff[ACC_BITS-2:0], q_bit};
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.grad_load) begin
         grad_ff <= grad_in;
      end
      if (cmd.emit && cmd.emit_kind == EMIT_FIRST) begin
         acc_ff <= {na_ff, {FRAC_BITS{1'b0}}} + grad_ext;
         col_ff <= ma_ff + COORD_BITS'(1);
      end else if (cmd.emit && cmd.emit_kind == EMIT_INTERIOR) begin
         acc_ff <= acc_ff + grad_ext;
         col_ff <= col_next[COORD_BITS-1:0];
      end
   end

   // result word selection
   logic [COORD_BITS-1:0]  sel_major, sel_minor;
   logic [WEIGHT_BITS:0]   sel_near;
   logic [WEIGHT_BITS-1:0] sel_far;
   logic                   sel_last;
   logic                   interior_last;

   assign interior_last = col_next == {1'b0, mb_ff};

   always_comb begin
      sel_major = ma_ff;
      sel_minor = na_ff;
      sel_near  = WEIGHT_HALF;
      sel_far   = WEIGHT_NONE;
      sel_last  = 1'b0;
      case (cmd.emit_kind)
         EMIT_FIRST: begin
            sel_major = ma_ff;
            sel_minor = na_ff;
         end
         EMIT_SECOND: begin
            sel_major = mb_ff;
            sel_minor = nb_ff;
            sel_last  = dmaj_ff <= COORD_BITS'(1);
         end
         EMIT_INTERIOR: begin
            sel_major = col_ff;
            sel_minor = acc_ff[ACC_BITS-1:FRAC_BITS];
            sel_far   = acc_ff[FRAC_BITS-1:FRAC_BITS-WEIGHT_BITS];
            sel_near  = WEIGHT_FULL - {1'b0, sel_far};
            sel_last  = interior_last;
         end
         default: begin
            sel_last = 1'b0;
         end
      endcase
   end

   logic out_free;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit && out_free) begin
         out_x_ff     <= steep_ff ? sel_minor : sel_major;
         out_y_ff     <= steep_ff ? sel_major : sel_minor;
         out_far_x_ff <= steep_ff;
         out_near_ff  <= sel_near;
         out_far_ff   <= sel_far;
         out_last_ff  <= sel_last;
      end
   end

   always_comb begin
      status.dmaj_zero     = dmaj_ff == '0;
      status.dmaj_small    = dmaj_ff <= COORD_BITS'(1);
      status.div_done      = cnt_ff == '0;
      status.out_free      = out_free;
      status.interior_last = interior_last;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_far_on_x    = out_far_x_ff;
   assign rsp_weight_near = out_near_ff;
   assign rsp_weight_far  = out_far_ff;
   assign rsp_last        = out_last_ff;

endmodule

### rtl/core/antialiased_line_rasterizer.sv
// top level of the antialiased line rasteriser
`timescale 1ns / 1ps

// Antialiased line rasteriser (Wu style, integer endpoints). One request word
// carries a line; the block answers with one response word per major-axis
// column: the first endpoint, then the second endpoint, then the interior
// columns in ascending order, the final word flagged by last. Each word names
// a near pixel and says whether its partner sits one column right (steep line)
// or one row down, with Q1.8 near and Q0.8 far weights where 256 is full
// intensity; both endpoints carry 128 and 0. A line is accepted, then the
// restoring divider forms the Q1.16 gradient, one quotient bit a cycle over
// 22 quotient bits (cut short when both columns match), the gradient is
// set, and then one response word goes out per cycle while the response
// side keeps up. A new line is taken only once the previous one has been
// handed to the response register; the last word may still wait there while
// the next line is accepted.

module antialiased_line_rasterizer
   import aalr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y,
   output logic                   rsp_far_on_x,
   output logic [WEIGHT_BITS:0]   rsp_weight_near,
   output logic [WEIGHT_BITS-1:0] rsp_weight_far,
   output logic                   rsp_last
);

   // commands down to the datapath, status back up
   cmd_type    cmd;
   status_type status;

   // sequencer: divide, set gradient, then one word per column
   aalr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // geometry, divider, minor accumulator and response register
   aalr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_far_on_x    (rsp_far_on_x),
      .rsp_weight_near (rsp_weight_near),
      .rsp_weight_far  (rsp_weight_far),
      .rsp_last        (rsp_last)
   );

endmodule

### test/antialiased_line_rasterizer_test.sv
// self-checking testbench for the antialiased line rasteriser
`timescale 1ns / 1ps

// Lines go in on the request channel and every pixel-pair word that comes back
// is checked, field by field, against a queue of expected words. A short table
// of hand-picked lines runs first. Rows whose two words can be read straight
// off the line (zero length, adjacent columns) carry them typed in. Every other
// row goes through the in-house Wu line predictor, and so do the random lines
// that follow. Both channels idle at random, apart from one calm stretch.

module antialiased_line_rasterizer_test
   import aalr_pkg::*;
();

   localparam int N_TABLE        = 18;
   localparam int N_RANDOM       = 392;
   localparam int CALM_FIRST     = 150;   // lines in this window see no idling
   localparam int CALM_LAST      = 260;
   localparam int DRAIN_CYCLES   = 100;
   localparam int QUIET_LIMIT    = 5000;  // cycles with no word moving at all

   // one expected response word
   typedef struct packed {
      logic [COORD_BITS-1:0]  pixel_x;
      logic [COORD_BITS-1:0]  pixel_y;
      logic                   far_on_x;
      logic [WEIGHT_BITS:0]   weight_near;
      logic [WEIGHT_BITS-1:0] weight_far;
      logic                   last;
   } pixel_word_type;

   // one row of the directed table; typed rows hold their two endpoint pixels
   typedef struct {
      int sx, sy, ex, ey;
      bit typed;
      int x0, y0, x1, y1;
      bit far_x;
   } line_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_stall;
   logic [COORD_BITS-1:0]  req_start_x;
   logic [COORD_BITS-1:0]  req_start_y;
   logic [COORD_BITS-1:0]  req_end_x;
   logic [COORD_BITS-1:0]  req_end_y;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_BITS-1:0]  rsp_pixel_x;
   logic [COORD_BITS-1:0]  rsp_pixel_y;
   logic                   rsp_far_on_x;
   logic [WEIGHT_BITS:0]   rsp_weight_near;
   logic [WEIGHT_BITS-1:0] rsp_weight_far;
   logic                   rsp_last;

   // predictor state, mirrors the block's registers
   logic [ACC_BITS-1:0]    wu_minor_acc;
   logic [GRAD_BITS-1:0]   wu_gradient;
   logic [COORD_BITS-1:0]  wu_column;
   logic [COORD_BITS-1:0]  wu_last_column;
   logic                   wu_steep;

   pixel_word_type pending_pixels[$];
   line_row_type   line_table[N_TABLE];

   int  lines_sent     = 0;
   int  steep_lines    = 0;
   int  words_checked  = 0;
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  no_idle;

   antialiased_line_rasterizer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_far_on_x    (rsp_far_on_x),
      .rsp_weight_near (rsp_weight_near),
      .rsp_weight_far  (rsp_weight_far),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // calm window: neither side idles while these lines go through
   assign no_idle = (lines_sent >= CALM_FIRST) && (lines_sent < CALM_LAST);

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0d want %0d (word %0d)",
               $realtime, what, got, want, words_checked);
   endtask

   function automatic void push_word(input int px, input int py, input bit far_x,
                                     input int near_w, input int far_w, input bit fin);
      pixel_word_type w;
      w.pixel_x     = COORD_BITS'(px);
      w.pixel_y     = COORD_BITS'(py);
      w.far_on_x    = far_x;
      w.weight_near = (WEIGHT_BITS + 1)'(near_w);
      w.weight_far  = WEIGHT_BITS'(far_w);
      w.last        = fin;
      pending_pixels.push_back(w);
   endfunction

   // Wu line: both endpoints at half weight, then interior columns off the
   // fixed-point minor accumulator
   task automatic rasterise_line(input int sx, input int sy, input int ex, input int ey);
      int     adx, ady, ma, na, mb, nb, swap_tmp, d_major, d_minor, col, minor;
      longint grad, mag;
      logic [WEIGHT_BITS-1:0] fw;
      adx = ex > sx ? ex - sx : sx - ex;
      ady = ey > sy ? ey - sy : sy - ey;
      wu_steep = ady > adx;
      if (wu_steep) begin
         ma = sy; na = sx; mb = ey; nb = ex;
         steep_lines++;
      end else begin
         ma = sx; na = sy; mb = ex; nb = ey;
      end
      // walk the major axis upwards
      if (ma > mb) begin
         swap_tmp = ma; ma = mb; mb = swap_tmp;
         swap_tmp = na; na = nb; nb = swap_tmp;
      end
      d_major = mb - ma;
      d_minor = nb - na;
      // truncation toward zero, gradient of one when the columns match
      if (d_major == 0) begin
         grad = longint'(1) << FRAC_BITS;
      end else begin
         mag  = (longint'(d_minor < 0 ? -d_minor : d_minor) << FRAC_BITS) / d_major;
         grad = d_minor < 0 ? -mag : mag;
      end
      wu_gradient    = GRAD_BITS'(grad);
      wu_last_column = COORD_BITS'(mb);

      push_word(wu_steep ? na : ma, wu_steep ? ma : na, wu_steep,
                int'(WEIGHT_HALF), int'(WEIGHT_NONE), 1'b0);
      wu_column = COORD_BITS'(mb);
      push_word(wu_steep ? nb : mb, wu_steep ? mb : nb, wu_steep,
                int'(WEIGHT_HALF), int'(WEIGHT_NONE), d_major <= 1);

      wu_minor_acc = ACC_BITS'((longint'(na) << FRAC_BITS) + grad);
      for (col = ma + 1; col < mb; col++) begin
         fw    = wu_minor_acc[FRAC_BITS-1 -: WEIGHT_BITS];
         minor = int'(wu_minor_acc[ACC_BITS-1:FRAC_BITS]);
         wu_column = COORD_BITS'(col);
         push_word(wu_steep ? minor : col, wu_steep ? col : minor, wu_steep,
                   int'(WEIGHT_FULL) - int'(fw), int'(fw), col + 1 == mb);
         wu_minor_acc = wu_minor_acc + ACC_BITS'(grad);
      end
   endtask

   // hand one line over and hold it until the block takes it
   task automatic offer_line(input int sx, input int sy, input int ex, input int ey);
      while (!no_idle && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_start_x <= COORD_BITS'(sx);
      req_start_y <= COORD_BITS'(sy);
      req_end_x   <= COORD_BITS'(ex);
      req_end_y   <= COORD_BITS'(ey);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lines_sent++;
   endtask

   // response side backs off now and then, except in the calm window
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 10);
   end

   // take each accepted word against the oldest expectation
   always @(posedge clock) begin
      pixel_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected word, pixel_x", rsp_pixel_x, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.pixel_x)
               report_mismatch("pixel_x", rsp_pixel_x, want.pixel_x);
            if (rsp_pixel_y !== want.pixel_y)
               report_mismatch("pixel_y", rsp_pixel_y, want.pixel_y);
            if (rsp_far_on_x !== want.far_on_x)
               report_mismatch("far_on_x", rsp_far_on_x, want.far_on_x);
            if (rsp_weight_near !== want.weight_near)
               report_mismatch("weight_near", rsp_weight_near, want.weight_near);
            if (rsp_weight_far !== want.weight_far)
               report_mismatch("weight_far", rsp_weight_far, want.weight_far);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
         words_checked++;
      end
   end

   // watchdog: a hung handshake on either side ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no word moved for %0d cycles", QUIET_LIMIT);
            $display("antialiased_line_rasterizer regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int sx, sy, ex, ey, pick, n;
      req_valid   <= 1'b0;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x   <= '0;
      req_end_y   <= '0;

      // typed rows carry their two endpoint pixels; the rest are predicted
      line_table = '{
         '{ 0,  0,  0,  0, 1,  0,  0,  0,  0, 0},   // zero length at the origin
         '{63, 63, 63, 63, 1, 63, 63, 63, 63, 0},   // zero length at the far corner
         '{10, 20, 11, 20, 1, 10, 20, 11, 20, 0},   // adjacent columns
         '{ 5, 40,  5, 39, 1,  5, 39,  5, 40, 1},   // adjacent rows, steep and reversed
         '{63,  0, 62,  0, 1, 62,  0, 63,  0, 0},   // adjacent columns, reversed
         '{ 0,  0, 63, 63, 0,  0,  0,  0,  0, 0},   // full diagonal, gradient one
         '{63,  0,  0, 63, 0,  0,  0,  0,  0, 0},   // full anti-diagonal
         '{ 0,  0, 63,  0, 0,  0,  0,  0,  0, 0},   // full horizontal
         '{ 0,  0,  0, 63, 0,  0,  0,  0,  0, 0},   // full vertical
         '{63, 63,  0,  0, 0,  0,  0,  0,  0, 0},   // diagonal drawn backwards
         '{17,  3,  2, 60, 0,  0,  0,  0,  0, 0},   // steep, falling minor
         '{ 1,  0, 62,  1, 0,  0,  0,  0,  0, 0},   // shallow, tiny gradient
         '{ 0,  1, 63,  0, 0,  0,  0,  0,  0, 0},   // shallow, tiny negative gradient
         '{21, 42, 42, 21, 0,  0,  0,  0,  0, 0},   // alternating bit patterns
         '{42, 21, 21, 42, 0,  0,  0,  0,  0, 0},
         '{30, 30, 33, 31, 0,  0,  0,  0,  0, 0},   // short line, two interior columns
         '{ 7,  9,  8, 12, 0,  0,  0,  0,  0, 0},   // short steep line
         '{ 0, 63, 63, 62, 0,  0,  0,  0,  0, 0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < N_TABLE; n++) begin
         offer_line(line_table[n].sx, line_table[n].sy, line_table[n].ex, line_table[n].ey);
         if (line_table[n].typed) begin
            push_word(line_table[n].x0, line_table[n].y0, line_table[n].far_x,
                      int'(WEIGHT_HALF), int'(WEIGHT_NONE), 1'b0);
            push_word(line_table[n].x1, line_table[n].y1, line_table[n].far_x,
                      int'(WEIGHT_HALF), int'(WEIGHT_NONE), 1'b1);
         end else begin
            rasterise_line(line_table[n].sx, line_table[n].sy,
                           line_table[n].ex, line_table[n].ey);
         end
      end

      // random lines: mostly anywhere on the grid, plenty of short ones,
      // some degenerate and some axis-aligned
      for (n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(99);
         sx   = $urandom_range(63);
         sy   = $urandom_range(63);
         ex   = $urandom_range(63);
         ey   = $urandom_range(63);
         if (pick >= 60 && pick < 85) begin
            ex = (sx + $urandom_range(6) + 61) % 64;
            ey = (sy + $urandom_range(6) + 61) % 64;
         end else if (pick >= 85 && pick < 93) begin
            ex = (sx + $urandom_range(1)) % 64;
            ey = (sy + $urandom_range(2) + 63) % 64;
         end else if (pick >= 93) begin
            if ($urandom_range(1)) ex = sx;
            else ey = sy;
         end
         offer_line(sx, sy, ex, ey);
         rasterise_line(sx, sy, ex, ey);
      end
      req_valid <= 1'b0;

      // drain, then give any stray word time to show up
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("lines sent: %0d (%0d from the table, %0d steep predicted)",
               lines_sent, N_TABLE, steep_lines);
      $display("pixel words checked: %0d, mismatches: %0d", words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("antialiased_line_rasterizer regression: pass");
      end else begin
         $display("antialiased_line_rasterizer regression: fail");
      end
      $finish;
   end

endmodule
